// ===== design/lsr3_pkg.sv =====
// Shared types and constants for the 3x3 Laplacian sharpening block.
package lsr3_pkg;

  localparam int CH_W       = 8;
  localparam int PIX_W      = 3 * CH_W;
  localparam int IMG_W_BITS = 11;
  localparam int IMG_H_BITS = 13;
  localparam int MIN_DIM    = 3;
  localparam int OUTQ_DEPTH = 8;
  localparam int APB_AW     = 3;
  localparam int APB_DW     = 32;

  localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd640;
  localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 13'd480;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef enum logic [1:0] {
    SEQ_SIZE,
    SEQ_PROD,
    SEQ_DIV,
    SEQ_RUN
  } seq_state_e;

  typedef struct packed {
    logic size_ld;
    logic prod_ld;
    logic div_en;
    logic run;
  } seq_ctl_t;

endpackage

// ===== design/laplacian_sharpen_rgb_3x3.sv =====
// Top level of the 3x3 Laplacian sharpening block for 24-bit RGB pixel streams.
//
// Input stream: one pixel word per handshake, raster order. tuser = 0 carries a pixel,
// tuser = 1 is a drain tick. Drain ticks before a frame is fully fed are dropped.
// After the last pixel of a frame, width+1 more words (drain or pixel) flush the tail.
// Output stream: one sharpened pixel per word; tlast marks the last pixel of the frame.
// The output for a pixel appears width+1 input words later, and a word that yields an
// output passes the read, window shift, sum and result steps after its acceptance.
// Throughput is one word per cycle while tready is high, set by one read and one write
// per cycle on a single 48-bit line-buffer RAM that holds both previous rows.
// Sizes are set over APB: image_width at 0x0, image_height at 0x4, clamped to 3..max.
// After reset and after every register write, tready stays low while the clamped sizes,
// their product and the row/column split of the output position are recomputed by a
// bit-serial divider.
// A stalled receiver fills an 8-word output queue; tready drops once the queue
// plus the words in the pipeline would fill it, so nothing is lost.
module laplacian_sharpen_rgb_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // chan0 [7:0], chan1 [15:8], chan2 [23:16]
  input  logic [lsr3_pkg::PIX_W-1:0]          s_tdata,
  // op [0]
  input  logic [0:0]                          s_tuser,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // chan0_out [7:0], chan1_out [15:8], chan2_out [23:16]
  output logic [lsr3_pkg::PIX_W-1:0]          m_tdata,
  output logic                                m_tlast,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lsr3_pkg::APB_AW-1:0]         paddr,
  input  logic [lsr3_pkg::APB_DW-1:0]         pwdata,
  output logic [lsr3_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int PW  = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PRW = WW + HW;
  localparam int DCW = $clog2(PW);
  localparam int CHW = lsr3_pkg::CH_W;
  localparam int PXW = lsr3_pkg::PIX_W;
  localparam int QD  = lsr3_pkg::OUTQ_DEPTH;
  localparam int QAW = $clog2(QD);
  localparam int QCW = $clog2(QD + 1);

  // ---------------- configuration ----------------
  logic [lsr3_pkg::IMG_W_BITS-1:0] img_w_q;
  logic [lsr3_pkg::IMG_H_BITS-1:0] img_h_q;
  logic                            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_w_q <= lsr3_pkg::IMG_W_RESET;
      img_h_q <= lsr3_pkg::IMG_H_RESET;
    end else if (cfg_wr) begin
      case (paddr[2])
        lsr3_pkg::REG_IMAGE_WIDTH:  img_w_q <= pwdata[lsr3_pkg::IMG_W_BITS-1:0];
        lsr3_pkg::REG_IMAGE_HEIGHT: img_h_q <= pwdata[lsr3_pkg::IMG_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      lsr3_pkg::REG_IMAGE_WIDTH:  prdata = lsr3_pkg::APB_DW'(img_w_q);
      lsr3_pkg::REG_IMAGE_HEIGHT: prdata = lsr3_pkg::APB_DW'(img_h_q);
      default:                    prdata = '0;
    endcase
  end

  // ---------------- size sequencer ----------------
  lsr3_pkg::seq_state_e seq_q, seq_d;
  lsr3_pkg::seq_ctl_t   ctl;

  logic [WW-1:0]  w_q;
  logic [HW-1:0]  h_q;
  logic [PRW-1:0] wh_q;
  logic [WW-1:0]  div_rem_q, div_rem_d;
  logic [PW-1:0]  div_quo_q, div_quo_d;
  logic [DCW-1:0] div_cnt_q;
  logic [WW:0]    div_trial;
  logic           div_ge;
  logic           div_done;

  assign div_done = ctl.div_en && (div_cnt_q == DCW'(PW - 1));

  always_comb begin
    seq_d = seq_q;
    if (cfg_wr) begin
      seq_d = lsr3_pkg::SEQ_SIZE;
    end else begin
      case (seq_q)
        lsr3_pkg::SEQ_SIZE: seq_d = lsr3_pkg::SEQ_PROD;
        lsr3_pkg::SEQ_PROD: seq_d = lsr3_pkg::SEQ_DIV;
        lsr3_pkg::SEQ_DIV:  if (div_done) seq_d = lsr3_pkg::SEQ_RUN;
        lsr3_pkg::SEQ_RUN:  seq_d = lsr3_pkg::SEQ_RUN;
        default:            seq_d = lsr3_pkg::SEQ_SIZE;
      endcase
    end
  end

  always_comb begin
    ctl = '0;
    case (seq_q)
      lsr3_pkg::SEQ_SIZE: ctl.size_ld = 1'b1;
      lsr3_pkg::SEQ_PROD: ctl.prod_ld = 1'b1;
      lsr3_pkg::SEQ_DIV:  ctl.div_en  = 1'b1;
      lsr3_pkg::SEQ_RUN:  ctl.run     = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q <= lsr3_pkg::SEQ_SIZE;
    end else begin
      seq_q <= seq_d;
    end
  end

  assign div_trial = {div_rem_q, div_quo_q[PW-1]};
  assign div_ge    = div_trial >= {1'b0, w_q};
  assign div_rem_d = div_ge ? WW'(div_trial - {1'b0, w_q}) : WW'(div_trial);
  assign div_quo_d = {div_quo_q[PW-2:0], div_ge};

  logic [PW-1:0] pos_q;

  always_ff @(posedge clk_i) begin
    if (ctl.size_ld) begin
      w_q <= (int'(img_w_q) < lsr3_pkg::MIN_DIM) ? WW'(lsr3_pkg::MIN_DIM) :
             (int'(img_w_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(img_w_q);
      h_q <= (int'(img_h_q) < lsr3_pkg::MIN_DIM) ? HW'(lsr3_pkg::MIN_DIM) :
             (int'(img_h_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(img_h_q);
    end
    if (ctl.prod_ld) begin
      wh_q      <= PRW'(w_q) * PRW'(h_q);
      div_rem_q <= '0;
      div_quo_q <= pos_q;
      div_cnt_q <= '0;
    end else if (ctl.div_en) begin
      div_rem_q <= div_rem_d;
      div_quo_q <= div_quo_d;
      div_cnt_q <= div_cnt_q + DCW'(1);
    end
  end

  // ---------------- input stage and position counters ----------------
  logic [CW-1:0] in_col_q;
  logic [RW-1:0] in_row_q;
  logic          tail_q;
  logic [PW-1:0] qr_q;
  logic [CW-1:0] qc_q;

  logic [QCW-1:0] outq_cnt_q;
  logic           s1_v_q, s1_out_q, s2_out_q, s3_out_q;
  logic [QCW-1:0] pending;

  logic           acc, eff, primed, col_wrap, row_last, last, border;
  logic [WW-1:0]  col_inc, qc_inc;
  logic [PRW-1:0] pos_inc;
  logic [PW:0]    qr_inc;
  logic [PXW-1:0] px;

  assign pending  = outq_cnt_q + QCW'(s1_out_q) + QCW'(s2_out_q) + QCW'(s3_out_q);
  assign s_tready = ctl.run && (pending < QCW'(QD));
  assign acc      = s_tvalid & s_tready;
  assign eff      = acc & ~((s_tuser[0] == lsr3_pkg::OP_DRAIN) & ~tail_q);
  assign px       = tail_q ? '0 : s_tdata;

  assign col_inc  = WW'(in_col_q) + WW'(1);
  assign col_wrap = col_inc >= w_q;
  assign row_last = (HW'(in_row_q) + HW'(1)) >= h_q;
  assign primed   = tail_q || (in_row_q >= RW'(2)) || (in_row_q == RW'(1) && in_col_q != '0);
  assign pos_inc  = PRW'(pos_q) + PRW'(1);
  assign last     = pos_inc >= wh_q;
  assign qc_inc   = WW'(qc_q) + WW'(1);
  assign qr_inc   = (PW + 1)'(qr_q) + (PW + 1)'(1);
  assign border   = (qr_q == '0) || (qr_inc >= (PW + 1)'(h_q)) || (qc_q == '0) ||
                    (qc_inc >= w_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q <= '0;
      in_row_q <= '0;
      tail_q   <= 1'b0;
      pos_q    <= '0;
      qr_q     <= '0;
      qc_q     <= '0;
    end else if (div_done) begin
      qr_q <= div_quo_d;
      qc_q <= div_rem_d[CW-1:0];
    end else if (eff) begin
      if (primed && last) begin
        in_col_q <= '0;
        in_row_q <= '0;
        tail_q   <= 1'b0;
        pos_q    <= '0;
        qr_q     <= '0;
        qc_q     <= '0;
      end else begin
        in_col_q <= col_wrap ? '0 : col_inc[CW-1:0];
        if (col_wrap && !tail_q) begin
          if (row_last) begin
            tail_q <= 1'b1;
          end else begin
            in_row_q <= in_row_q + RW'(1);
          end
        end
        if (primed) begin
          pos_q <= PW'(pos_inc);
          if (qc_inc >= w_q) begin
            qc_q <= '0;
            qr_q <= qr_inc[PW-1:0];
          end else begin
            qc_q <= qc_inc[CW-1:0];
          end
        end
      end
    end
  end

  // ---------------- stage 1: line buffer read-modify-write ----------------
  logic [CW-1:0]    s1_addr_q;
  logic [PXW-1:0]   s1_px_q;
  logic             s1_border_q, s1_last_q, s1_fwd_q;
  logic [PXW-1:0]   wr_px_q, wr_mid_q;
  logic [2*PXW-1:0] ram_rdata;
  logic [PXW-1:0]   up_px, mid_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q   <= 1'b0;
      s1_out_q <= 1'b0;
      s1_fwd_q <= 1'b0;
    end else begin
      s1_v_q   <= eff;
      s1_out_q <= eff & primed;
      s1_fwd_q <= eff & s1_v_q & (s1_addr_q == in_col_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (eff) begin
      s1_addr_q   <= in_col_q;
      s1_px_q     <= px;
      s1_border_q <= border;
      s1_last_q   <= last;
    end
    if (s1_v_q) begin
      wr_px_q  <= s1_px_q;
      wr_mid_q <= mid_px;
    end
  end

  // upper row in the low half, middle row in the high half
  assign up_px  = s1_fwd_q ? wr_mid_q : ram_rdata[PXW-1:0];
  assign mid_px = s1_fwd_q ? wr_px_q  : ram_rdata[2*PXW-1:PXW];

  lsr3_ram #(
    .WIDTH(2 * PXW),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s1_v_q),
    .waddr_i (s1_addr_q),
    .wdata_i ({s1_px_q, mid_px}),
    .raddr_i (in_col_q),
    .rdata_o (ram_rdata)
  );

  logic [PXW-1:0] win_q [3][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_v_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up_px;
      win_q[1][2] <= mid_px;
      win_q[2][2] <= s1_px_q;
    end
  end

  // ---------------- stage 2: neighbour sums ----------------
  logic s2_border_q, s2_last_q;
  logic [CHW+2:0] nsum [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_out_q <= 1'b0;
    end else begin
      s2_out_q <= s1_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_border_q <= s1_border_q;
    s2_last_q   <= s1_last_q;
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      nsum[k] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          if (r != 1 || c != 1) begin
            nsum[k] = nsum[k] + (CHW + 3)'(win_q[r][c][k*CHW +: CHW]);
          end
        end
      end
    end
  end

  // ---------------- stage 3: clamp and subtract ----------------
  logic [CHW+2:0] s3_sum_q [3];
  logic [CHW-1:0] s3_ctr_q [3];
  logic           s3_border_q, s3_last_q;
  logic [PXW-1:0] res_px;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_out_q <= 1'b0;
    end else begin
      s3_out_q <= s2_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_border_q <= s2_border_q;
    s3_last_q   <= s2_last_q;
    for (int k = 0; k < 3; k++) begin
      s3_sum_q[k] <= nsum[k];
      s3_ctr_q[k] <= win_q[1][1][k*CHW +: CHW];
    end
  end

  function automatic logic [CHW-1:0] sharpen(input logic [CHW+2:0] sum,
                                              input logic [CHW-1:0] ctr);
    logic [CHW+2:0] ctr8;
    logic [CHW+2:0] diff;
    logic [CHW-1:0] lap;
    ctr8 = {ctr, 3'b000};
    diff = sum - ctr8;
    if (sum <= ctr8) begin
      lap = '0;
    end else if (diff > (CHW + 3)'(255)) begin
      lap = '1;
    end else begin
      lap = diff[CHW-1:0];
    end
    return (lap > ctr) ? '0 : ctr - lap;
  endfunction

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      res_px[k*CHW +: CHW] = s3_border_q ? s3_ctr_q[k] : sharpen(s3_sum_q[k], s3_ctr_q[k]);
    end
  end

  // ---------------- output queue ----------------
  logic [PXW:0]   outq_q [QD];
  logic [QAW-1:0] outq_wp_q, outq_rp_q;
  logic           pop;

  assign m_tvalid = outq_cnt_q != '0;
  assign pop      = m_tvalid & m_tready;
  assign m_tdata  = outq_q[outq_rp_q][PXW-1:0];
  assign m_tlast  = outq_q[outq_rp_q][PXW];

  always_ff @(posedge clk_i) begin
    if (s3_out_q) begin
      outq_q[outq_wp_q] <= {s3_last_q, res_px};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outq_wp_q  <= '0;
      outq_rp_q  <= '0;
      outq_cnt_q <= '0;
    end else begin
      if (s3_out_q) begin
        outq_wp_q <= outq_wp_q + QAW'(1);
      end
      if (pop) begin
        outq_rp_q <= outq_rp_q + QAW'(1);
      end
      outq_cnt_q <= outq_cnt_q + QCW'(s3_out_q) - QCW'(pop);
    end
  end

endmodule

// ===== design/lsr3_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lsr3_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lsr3_checker.sv =====
// Port-level checker for the 3x3 Laplacian sharpening block, with its bind.
module lsr3_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_tready,
  input logic [lsr3_pkg::PIX_W-1:0]  m_tdata,
  input logic                        m_tlast,
  input logic                        m_tvalid,
  input logic                        m_tready,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic                        pready
);

  // a stalled output word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // the output queue is empty while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !m_tvalid)
    else $error("output valid during reset");

  // a register write restarts the size setup and holds off input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=> !s_tready)
    else $error("input accepted right after a register write");

  // the size setup still holds off input once it has moved on to its product state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel && penable && pwrite && pready |=> ##1 !s_tready)
    else $error("input accepted during size setup");

endmodule

bind laplacian_sharpen_rgb_3x3 lsr3_checker u_lsr3_checker (.*);
